>>> rtl/dmtc_pkg.sv
package dmtc_pkg;

  // Payload widths.
  localparam int SYMBOL_W = 8;
  localparam int AMOUNT_W = 64;
  localparam int WHOLE_W  = 63;
  localparam int FRAC_W   = 7;
  localparam int COUNT_W  = 2;
  localparam int SUM_W    = WHOLE_W + FRAC_W;

  // Character codes.
  localparam logic [SYMBOL_W-1:0] CHAR_END   = 8'h00;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SYMBOL_W-1:0] CHAR_FIVE  = 8'h35;
  localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;

  // Largest dollar value that may still take another digit: (2^63-1-9)/10.
  localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 63'd922337203685477579;

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef logic [SYMBOL_W-1:0] symbol_t;
  typedef logic signed [AMOUNT_W-1:0] amount_t;

endpackage

>>> rtl/dmtc_text_if.sv
interface dmtc_text_if;
  logic valid;
  logic ready;
  dmtc_pkg::symbol_t symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

>>> rtl/dmtc_result_if.sv
interface dmtc_result_if;
  logic valid;
  logic ready;
  dmtc_pkg::amount_t amount;
  logic status;

  modport source (output valid, output amount, output status, input ready);
  modport sink (input valid, input amount, input status, output ready);
endinterface

>>> rtl/decimal_money_text_to_cents_core.sv
// Channel  | Dir | Payload                      | Request
// ---------+-----+------------------------------+-------------------------------
// text     | in  | symbol[7:0], 0 ends a string | one ASCII character
// result   | out | amount[63:0] signed, status  | cents and status per string
//
// One character is taken every cycle and the parser state updates in the cycle after it
// is registered, unless a terminator must wait for the finish stage. The longest path
// is the 70-bit dollars-times-100 add. A terminator's result passes finish, sum, sign.
// Reset (rst, synchronous) clears the parser state and empties every stage.
// A stall on result holds the pipeline back only when a terminator is queued behind it.
module decimal_money_text_to_cents_core (
  input logic clk,
  input logic rst,
  dmtc_text_if.sink text,
  dmtc_result_if.source result
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WHOLE = 2'd1,
    PH_FRAC  = 2'd2
  } phase_t;

  // Input register.
  logic s1_valid;
  dmtc_pkg::symbol_t s1_symbol;

  // Parser state.
  phase_t phase;
  logic is_negative;
  logic [dmtc_pkg::WHOLE_W-1:0] whole_part;
  logic whole_digit_seen;
  logic [dmtc_pkg::FRAC_W-1:0] fraction_value;
  logic [dmtc_pkg::COUNT_W-1:0] fraction_count;
  logic round_flag;
  logic failed;

  phase_t phase_next;
  logic is_negative_next;
  logic [dmtc_pkg::WHOLE_W-1:0] whole_part_next;
  logic whole_digit_seen_next;
  logic [dmtc_pkg::FRAC_W-1:0] fraction_value_next;
  logic [dmtc_pkg::COUNT_W-1:0] fraction_count_next;
  logic round_flag_next;
  logic failed_next;

  // Finish stage: dollars and cents of a completed string.
  logic f2_valid;
  logic [dmtc_pkg::WHOLE_W-1:0] f2_whole;
  logic [dmtc_pkg::FRAC_W-1:0] f2_cents;
  logic f2_negative;
  logic f2_bad;

  // Sum stage: dollars * 100 + cents.
  logic f3_valid;
  logic [dmtc_pkg::SUM_W-1:0] f3_sum;
  logic f3_negative;
  logic f3_bad;

  // Output register.
  logic o_valid;
  dmtc_pkg::amount_t o_amount;
  logic o_status;

  logic o_free, f3_free, f2_free, s1_adv, s1_end;
  logic is_digit;
  logic [3:0] digit;
  logic [dmtc_pkg::FRAC_W-1:0] cents;
  logic finish_bad;
  logic [dmtc_pkg::SUM_W-1:0] whole_wide;
  logic [dmtc_pkg::SUM_W-1:0] sum;
  logic overflow;

  // Stage flow: each stage moves when the one after it has room; only a terminator needs room in the finish stage.
  assign o_free  = !o_valid || result.ready;
  assign f3_free = !f3_valid || o_free;
  assign f2_free = !f2_valid || f3_free;
  assign s1_end  = (s1_symbol == dmtc_pkg::CHAR_END);
  assign s1_adv  = s1_valid && (!s1_end || f2_free);
  assign text.ready = !s1_valid || s1_adv;

  assign result.valid  = o_valid;
  assign result.amount = o_amount;
  assign result.status = o_status;

  // Character classes.
  assign is_digit = (s1_symbol >= dmtc_pkg::CHAR_ZERO) && (s1_symbol <= dmtc_pkg::CHAR_NINE);
  assign digit    = 4'(s1_symbol - dmtc_pkg::CHAR_ZERO);

  // Parser update for one non-terminator character.
  always_comb begin
    phase_next            = phase;
    is_negative_next      = is_negative;
    whole_part_next       = whole_part;
    whole_digit_seen_next = whole_digit_seen;
    fraction_value_next   = fraction_value;
    fraction_count_next   = fraction_count;
    round_flag_next       = round_flag;
    failed_next           = failed;
    if (!failed) begin
      if (phase == PH_START || phase == PH_WHOLE) begin
        if (phase == PH_START) begin
          phase_next = PH_WHOLE;
        end
        if (is_digit) begin
          if (whole_part > dmtc_pkg::WHOLE_LIMIT) begin
            failed_next = 1'b1;
          end else begin
            whole_part_next = (whole_part << 3) + (whole_part << 1)
                              + dmtc_pkg::WHOLE_W'(digit);
            whole_digit_seen_next = 1'b1;
          end
        end else if (s1_symbol == dmtc_pkg::CHAR_DOT) begin
          phase_next = PH_FRAC;
        end else if (s1_symbol == dmtc_pkg::CHAR_MINUS && phase == PH_START) begin
          is_negative_next = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end else begin
        if (!is_digit) begin
          failed_next = 1'b1;
        end else if (fraction_count < 2'd2) begin
          fraction_value_next = (fraction_value << 3) + (fraction_value << 1)
                                + dmtc_pkg::FRAC_W'(digit);
          fraction_count_next = fraction_count + 2'd1;
        end else if (fraction_count == 2'd2) begin
          round_flag_next     = (s1_symbol >= dmtc_pkg::CHAR_FIVE);
          fraction_count_next = 2'd3;
        end
      end
    end
  end

  // Cents and the text error at the terminator.
  always_comb begin
    case (fraction_count)
      2'd0:    cents = '0;
      2'd1:    cents = (fraction_value << 3) + (fraction_value << 1);
      default: cents = fraction_value;
    endcase
    cents = cents + dmtc_pkg::FRAC_W'(round_flag);
    finish_bad = failed || (!whole_digit_seen && fraction_count == 2'd0);
  end

  // Dollars times one hundred plus cents, wide enough to see overflow.
  assign whole_wide = dmtc_pkg::SUM_W'(f2_whole);
  assign sum = (whole_wide << 6) + (whole_wide << 5) + (whole_wide << 2)
               + dmtc_pkg::SUM_W'(f2_cents);
  assign overflow = (f3_sum[dmtc_pkg::SUM_W-1:dmtc_pkg::AMOUNT_W-1] != '0);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.ready && text.valid) begin
      s1_symbol <= text.symbol;
    end
  end

  // Parser state; a terminator returns it to the start of a string.
  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_end)) begin
      phase            <= PH_START;
      is_negative      <= 1'b0;
      whole_part       <= '0;
      whole_digit_seen <= 1'b0;
      fraction_value   <= '0;
      fraction_count   <= '0;
      round_flag       <= 1'b0;
      failed           <= 1'b0;
    end else if (s1_adv) begin
      phase            <= phase_next;
      is_negative      <= is_negative_next;
      whole_part       <= whole_part_next;
      whole_digit_seen <= whole_digit_seen_next;
      fraction_value   <= fraction_value_next;
      fraction_count   <= fraction_count_next;
      round_flag       <= round_flag_next;
      failed           <= failed_next;
    end
  end

  // Finish stage; an empty string enters as a clean zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f2_free) begin
      f2_valid <= s1_adv && s1_end;
    end
    if (f2_free && s1_adv && s1_end) begin
      if (phase == PH_START) begin
        f2_whole    <= '0;
        f2_cents    <= '0;
        f2_negative <= 1'b0;
        f2_bad      <= 1'b0;
      end else begin
        f2_whole    <= whole_part;
        f2_cents    <= cents;
        f2_negative <= is_negative;
        f2_bad      <= finish_bad;
      end
    end
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (f3_free) begin
      f3_valid <= f2_valid;
    end
    if (f3_free && f2_valid) begin
      f3_sum      <= sum;
      f3_negative <= f2_negative;
      f3_bad      <= f2_bad;
    end
  end

  // Output register: range check, sign and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= f3_valid;
    end
    if (o_free && f3_valid) begin
      if (f3_bad || overflow) begin
        o_amount <= '0;
        o_status <= dmtc_pkg::STATUS_INVALID;
      end else begin
        o_amount <= f3_negative ? -f3_sum[dmtc_pkg::AMOUNT_W-1:0]
                                : f3_sum[dmtc_pkg::AMOUNT_W-1:0];
        o_status <= dmtc_pkg::STATUS_OK;
      end
    end
  end

  // An invalid result always carries a zero amount.
  assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status == dmtc_pkg::STATUS_INVALID |-> o_amount == '0)
    else $error("invalid result with nonzero amount");

  // A retired terminator leaves the parser at the start of a clean string.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_end |=> phase == PH_START && whole_part == '0 && !failed)
    else $error("parser not cleared after terminator");

  // Once an error is latched the dollar accumulator freezes until the terminator.
  assert property (@(posedge clk) disable iff (rst)
    failed && !(s1_adv && s1_end) |=> $stable(whole_part) && failed)
    else $error("accumulator moved after error");

  // The cent digits never exceed ninety-nine.
  assert property (@(posedge clk) disable iff (rst)
    fraction_value <= dmtc_pkg::FRAC_W'(99))
    else $error("cent digits out of range");

  // A terminator never retires while the finish stage is blocked.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_end |-> f2_free)
    else $error("terminator overran finish stage");

endmodule

>>> tb/tb_decimal_money_text_to_cents_core.sv
// Tracks one money string at a time, predicts the cent amount and status
// for each terminator, and checks the results in order.
class cents_scoreboard;

  typedef enum bit [1:0] {
    AT_START   = 2'd0,
    IN_DOLLARS = 2'd1,
    IN_CENTS   = 2'd2
  } text_phase_t;

  localparam bit [63:0] AMOUNT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  text_phase_t phase;
  bit          negative;
  bit [62:0]   dollars;
  bit          dollar_seen;
  bit [6:0]    cent_value;
  bit [1:0]    cent_count;
  bit          half_up;
  bit          broken;

  dmtc_pkg::amount_t due_amount[$];
  bit                due_status[$];
  int                errors;
  int                results_seen;

  function new();
    errors = 0;
    results_seen = 0;
    clear_string();
  endfunction

  function void clear_string();
    phase       = AT_START;
    negative    = 1'b0;
    dollars     = '0;
    dollar_seen = 1'b0;
    cent_value  = '0;
    cent_count  = '0;
    half_up     = 1'b0;
    broken      = 1'b0;
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function int pending();
    return due_amount.size();
  endfunction

  function bit is_digit(dmtc_pkg::symbol_t c);
    return (c >= dmtc_pkg::CHAR_ZERO) && (c <= dmtc_pkg::CHAR_NINE);
  endfunction

  function void take_dollar_digit(dmtc_pkg::symbol_t c);
    if (dollars > dmtc_pkg::WHOLE_LIMIT) begin
      broken = 1'b1;
    end else begin
      dollars = dollars * 63'd10 + 63'(c - dmtc_pkg::CHAR_ZERO);
      dollar_seen = 1'b1;
    end
  endfunction

  function void take_cent_digit(dmtc_pkg::symbol_t c);
    if (cent_count < 2'd2) begin
      cent_value = cent_value * 7'd10 + 7'(c - dmtc_pkg::CHAR_ZERO);
      cent_count++;
    end else if (cent_count == 2'd2) begin
      half_up = (c >= dmtc_pkg::CHAR_FIVE);
      cent_count = 2'd3;
    end
  endfunction

  // Works out the result of the string that a terminator closes.
  function void close_string();
    bit [63:0] cents;
    bit [63:0] total;
    bit        bad;
    bad = broken;
    if (phase == AT_START) begin
      due_amount.push_back('0);
      due_status.push_back(dmtc_pkg::STATUS_OK);
      return;
    end
    if (!dollar_seen && cent_count == 2'd0)
      bad = 1'b1;
    cents = (cent_count == 2'd1) ? 64'(cent_value) * 64'd10 : 64'(cent_value);
    if (cent_count == 2'd0)
      cents = '0;
    if (half_up)
      cents = cents + 64'd1;
    if (!bad && {1'b0, dollars} > (AMOUNT_MAX - cents) / 64'd100)
      bad = 1'b1;
    if (bad) begin
      due_amount.push_back('0);
      due_status.push_back(dmtc_pkg::STATUS_INVALID);
      return;
    end
    total = {1'b0, dollars} * 64'd100 + cents;
    if (negative)
      total = ~total + 64'd1;
    due_amount.push_back(dmtc_pkg::amount_t'(total));
    due_status.push_back(dmtc_pkg::STATUS_OK);
  endfunction

  // Notes an accepted character; returns 0 when the block ignores it.
  function bit note_symbol(dmtc_pkg::symbol_t c);
    if (c == dmtc_pkg::CHAR_END) begin
      close_string();
      clear_string();
      return 1'b1;
    end
    if (broken)
      return 1'b0;
    case (phase)
      AT_START: begin
        if (c == dmtc_pkg::CHAR_MINUS) begin
          negative = 1'b1;
          phase = IN_DOLLARS;
        end else if (c == dmtc_pkg::CHAR_DOT) begin
          phase = IN_CENTS;
        end else if (is_digit(c)) begin
          phase = IN_DOLLARS;
          take_dollar_digit(c);
        end else begin
          phase = IN_DOLLARS;
          broken = 1'b1;
        end
      end
      IN_DOLLARS: begin
        if (is_digit(c))
          take_dollar_digit(c);
        else if (c == dmtc_pkg::CHAR_DOT)
          phase = IN_CENTS;
        else
          broken = 1'b1;
      end
      default: begin
        if (is_digit(c))
          take_cent_digit(c);
        else
          broken = 1'b1;
      end
    endcase
    return 1'b1;
  endfunction

  task check_result(dmtc_pkg::amount_t amount, logic status);
    dmtc_pkg::amount_t want_amount;
    bit                want_status;
    results_seen++;
    if (due_amount.size() == 0) begin
      report($sformatf("result %0d / %0b with no string pending", amount, status));
      return;
    end
    want_amount = due_amount.pop_front();
    want_status = due_status.pop_front();
    if (amount !== want_amount)
      report($sformatf("amount %0d, expected %0d", amount, want_amount));
    if (status !== want_status)
      report($sformatf("status %0b, expected %0b", status, want_status));
  endtask

endclass

module tb_decimal_money_text_to_cents_core;

  localparam int RANDOM_SYMBOLS = 2000;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int STALL_CYCLES   = 400;

  logic clk;
  logic rst;
  int   cycles;
  int   send_calm;
  int   take_calm;
  bit   pressure_done;

  dmtc_pkg::symbol_t text_q[$];
  cents_scoreboard   ledger;

  dmtc_text_if   text_ch();
  dmtc_result_if result_ch();

  decimal_money_text_to_cents_core DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_decimal_money_text_to_cents_core: FAIL");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, a few long, with calm stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      text_q.push_back(dmtc_pkg::symbol_t'(s[i]));
    text_q.push_back(dmtc_pkg::CHAR_END);
  endfunction

  function automatic dmtc_pkg::symbol_t any_digit();
    return dmtc_pkg::CHAR_ZERO + dmtc_pkg::symbol_t'($urandom_range(0, 9));
  endfunction

  function automatic dmtc_pkg::symbol_t any_byte();
    return dmtc_pkg::symbol_t'($urandom_range(1, 255));
  endfunction

  // Builds one random string: mostly well-formed amounts, some noise and
  // some strings broken by one odd character.
  function automatic void add_random_string();
    dmtc_pkg::symbol_t body[$];
    string             near_top;
    int                kind;
    int                n;
    int                spot;
    near_top = "922337203685477";
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) body.push_back(any_byte());
    end else begin
      if ($urandom_range(0, 3) == 0)
        body.push_back(dmtc_pkg::CHAR_MINUS);
      n = $urandom_range(0, 99);
      if (n < 70) begin
        repeat ($urandom_range(0, 4)) body.push_back(any_digit());
      end else if (n < 85) begin
        repeat ($urandom_range(5, 12)) body.push_back(any_digit());
      end else begin
        // Dollar values near the top of the range.
        for (int i = 0; i < near_top.len(); i++)
          body.push_back(dmtc_pkg::symbol_t'(near_top[i]));
        repeat ($urandom_range(1, 4))
          body.push_back(dmtc_pkg::CHAR_FIVE + dmtc_pkg::symbol_t'($urandom_range(0, 4)));
      end
      if ($urandom_range(0, 3) != 0) begin
        body.push_back(dmtc_pkg::CHAR_DOT);
        repeat ($urandom_range(0, 5)) body.push_back(any_digit());
      end
      if (kind >= 88) begin
        spot = $urandom_range(0, body.size());
        body.insert(spot, any_byte());
      end
    end
    foreach (body[i])
      text_q.push_back(body[i]);
    text_q.push_back(dmtc_pkg::CHAR_END);
  endfunction

  function automatic void add_directed();
    add_text("");
    add_text("0");
    add_text("-0.00");
    add_text("12.34");
    add_text("-7.5");
    add_text("-.5");
    add_text("5.");
    add_text("1.005");
    add_text(".995");
    add_text("0.994");
    add_text("3.14159");
    add_text("-");
    add_text(".");
    add_text("-.");
    add_text("--1");
    add_text("1-2");
    add_text("1..2");
    add_text("1/2:");
    // A byte with the top bit set, then digits that must be ignored.
    text_q.push_back(8'hFF);
    add_text("42");
    add_text("92233720368547758.07");
    add_text("-92233720368547758.07");
    add_text("92233720368547758.075");
    add_text("92233720368547758.08");
    add_text("922337203685477580");
    add_text("9223372036854775807");
  endfunction

  task automatic send_symbol(dmtc_pkg::symbol_t c, output bit used);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid  <= 1'b1;
    text_ch.symbol <= c;
    do @(posedge clk); while (!text_ch.ready);
    used = ledger.note_symbol(c);
  endtask

  task automatic send_queued(inout int counted);
    bit used;
    while (text_q.size() > 0) begin
      send_symbol(text_q.pop_front(), used);
      if (used)
        counted++;
    end
  endtask

  // Result receiver, with one long hold-off once traffic is flowing.
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!pressure_done && ledger.results_seen >= 100) begin
        pressure_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      stall = pick_gap(take_calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      ledger.check_result(result_ch.amount, result_ch.status);
  end

  // Reset, stimulus and end of run.
  initial begin
    int counted;
    ledger = new();
    send_calm = 0;
    counted = 0;
    rst <= 1'b1;
    text_ch.valid  <= 1'b0;
    text_ch.symbol <= dmtc_pkg::CHAR_END;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_directed();
    send_queued(counted);

    counted = 0;
    while (counted < RANDOM_SYMBOLS) begin
      add_random_string();
      send_queued(counted);
    end
    text_ch.valid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("tb_decimal_money_text_to_cents_core: PASS");
    end else begin
      $display("tb_decimal_money_text_to_cents_core: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dmtc_pkg.sv
rtl/dmtc_text_if.sv
rtl/dmtc_result_if.sv
rtl/decimal_money_text_to_cents_core.sv
tb/tb_decimal_money_text_to_cents_core.sv
